>>> src/sti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sti_pkg
// Shared defaults, register indexes and width helpers for the segment and
// triangle crossing test.
// ---------------------------------------------------------------------------
package sti_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int NUM_REGS        = 6;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } reg_idx_t;

  // normal component width
  function automatic int sti_nw(input int c);
    return 2 * (c + 1) + 1;
  endfunction

  // plane distance width
  function automatic int sti_dsw(input int c);
    return sti_nw(c) + (c + 1) + 2;
  endfunction

  // queue entry: cross flag, normal, vertices, numerator, denominator
  function automatic int sti_qw(input int c);
    return 1 + 3 * sti_nw(c) + 9 * c + sti_dsw(c) + sti_dsw(c) + 1;
  endfunction

endpackage

>>> src/sti_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sti_front
// Take triangle beats, form the normal and both plane distances, classify
// the segment as crossing the plane or not.
// ---------------------------------------------------------------------------
module sti_front import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int QW = sti_qw(COORD_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [9*COORD_BITS-1:0] in_data,
  input  logic [6*COORD_BITS-1:0] seg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [QW-1:0]           out_data
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int NPW  = 2 * DW;
  localparam int NW   = sti_nw(C);
  localparam int DPW  = NW + DW;
  localparam int DSW  = sti_dsw(C);
  localparam int DENW = DSW + 1;

  logic [6:0] vld;
  logic       en;

  logic [9*C-1:0] vtx1, vtx2, vtx3, vtx4, vtx5, vtx6, vtx7;
  logic signed [C-1:0]    a1 [3];
  logic signed [C-1:0]    b1 [3];
  logic signed [C-1:0]    c1 [3];
  logic signed [C-1:0]    sp [3];
  logic signed [C-1:0]    ep [3];
  logic signed [DW-1:0]   ab2 [3];
  logic signed [DW-1:0]   ac2 [3];
  logic signed [DW-1:0]   ds2 [3];
  logic signed [DW-1:0]   de2 [3];
  logic signed [DW-1:0]   ds3 [3];
  logic signed [DW-1:0]   de3 [3];
  logic signed [DW-1:0]   ds4 [3];
  logic signed [DW-1:0]   de4 [3];
  logic signed [NPW-1:0]  pn3 [6];
  logic signed [NW-1:0]   n4 [3];
  logic signed [NW-1:0]   n5 [3];
  logic signed [NW-1:0]   n6 [3];
  logic signed [NW-1:0]   n7 [3];
  logic signed [DPW-1:0]  pd5 [3];
  logic signed [DPW-1:0]  pe5 [3];
  logic signed [DSW-1:0]  d16, d26;
  logic [DSW-1:0]         m1, m2;
  logic                   cross7;
  logic [DSW-1:0]         num7;
  logic [DENW-1:0]        den7;

  assign en        = !vld[6] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a1[i] = $signed(vtx1[i*C +: C]);
      b1[i] = $signed(vtx1[(3+i)*C +: C]);
      c1[i] = $signed(vtx1[(6+i)*C +: C]);
      sp[i] = $signed(seg[i*C +: C]);
      ep[i] = $signed(seg[(3+i)*C +: C]);
    end
    m1 = d16[DSW-1] ? -d16 : d16;
    m2 = d26[DSW-1] ? -d26 : d26;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx1 <= in_data;
      vtx2 <= vtx1;
      vtx3 <= vtx2;
      vtx4 <= vtx3;
      vtx5 <= vtx4;
      vtx6 <= vtx5;
      vtx7 <= vtx6;
      for (int i = 0; i < 3; i++) begin
        ab2[i] <= DW'(b1[i]) - DW'(a1[i]);
        ac2[i] <= DW'(c1[i]) - DW'(a1[i]);
        ds2[i] <= DW'(sp[i]) - DW'(a1[i]);
        de2[i] <= DW'(ep[i]) - DW'(a1[i]);
        ds3[i] <= ds2[i];
        de3[i] <= de2[i];
        ds4[i] <= ds3[i];
        de4[i] <= de3[i];
        n4[i]  <= NW'(pn3[2*i]) - NW'(pn3[2*i+1]);
        n5[i]  <= n4[i];
        n6[i]  <= n5[i];
        n7[i]  <= n6[i];
        pd5[i] <= n4[i] * ds4[i];
        pe5[i] <= n4[i] * de4[i];
      end
      pn3[0] <= ab2[1] * ac2[2];
      pn3[1] <= ab2[2] * ac2[1];
      pn3[2] <= ab2[2] * ac2[0];
      pn3[3] <= ab2[0] * ac2[2];
      pn3[4] <= ab2[0] * ac2[1];
      pn3[5] <= ab2[1] * ac2[0];
      d16    <= DSW'(pd5[0]) + DSW'(pd5[1]) + DSW'(pd5[2]);
      d26    <= DSW'(pe5[0]) + DSW'(pe5[1]) + DSW'(pe5[2]);
      cross7 <= (d16 != '0) && (d26 != '0) && (d16[DSW-1] != d26[DSW-1]);
      num7   <= m1;
      den7   <= DENW'(m1) + DENW'(m2);
    end
  end

  assign out_data = {den7, num7, vtx7, n7[2], n7[1], n7[0], cross7};

endmodule

>>> src/sti_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sti_queue
// Short queue between the classify front and the intersect back.
// ---------------------------------------------------------------------------
module sti_queue import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int QW = sti_qw(COORD_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [QW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [QW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

>>> src/sti_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sti_back
// Divide for t one bit per stage, interpolate the crossing point, run the
// edge-side test for each triangle edge and hold the result beat.
// ---------------------------------------------------------------------------
module sti_back import sti_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
  localparam int QW = sti_qw(COORD_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [QW-1:0]           in_data,
  input  logic [6*COORD_BITS-1:0] seg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [COORD_BITS-1:0]   hit_x,
  output logic [COORD_BITS-1:0]   hit_y,
  output logic [COORD_BITS-1:0]   hit_z
);

  localparam int C    = COORD_BITS;
  localparam int T    = T_FRAC_BITS;
  localparam int DW   = C + 1;
  localparam int NPW  = 2 * DW;
  localparam int NW   = sti_nw(C);
  localparam int DSW  = sti_dsw(C);
  localparam int DENW = DSW + 1;
  localparam int LW   = 1 + 3 * NW + 9 * C;
  localparam int PW   = LW + DENW;
  localparam int MW   = DW + T + 1;
  localparam int EPW  = 2 * NW;
  localparam int ESW  = EPW + 2;
  localparam int NS   = T + 6;

  logic [NS-1:0] vld;
  logic          en;

  assign en        = !vld[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  logic signed [C-1:0] sp [3];
  logic signed [C-1:0] ep [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp[i] = $signed(seg[i*C +: C]);
      ep[i] = $signed(seg[(3+i)*C +: C]);
    end
  end

  // restoring division, one quotient bit per stage
  logic [DENW-1:0] src_r [T];
  logic [T-1:0]    src_q [T];
  logic [PW-1:0]   src_p [T];
  logic [DENW-1:0] dr [T];
  logic [T-1:0]    dq [T];
  logic [PW-1:0]   dpl [T];

  for (genvar k = 0; k < T; k++) begin : g_div
    logic [DENW:0]   r2;
    logic [DENW-1:0] den;
    logic            ge;
    if (k == 0) begin : g_first
      assign src_r[k] = DENW'(in_data[LW +: DSW]);
      assign src_q[k] = '0;
      assign src_p[k] = {in_data[LW+DSW +: DENW], in_data[LW-1:0]};
    end else begin : g_rest
      assign src_r[k] = dr[k-1];
      assign src_q[k] = dq[k-1];
      assign src_p[k] = dpl[k-1];
    end
    assign den = src_p[k][PW-1 -: DENW];
    assign r2  = {src_r[k], 1'b0};
    assign ge  = r2 >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (en) begin
        dr[k]  <= ge ? DENW'(r2 - {1'b0, den}) : r2[DENW-1:0];
        dq[k]  <= {src_q[k][T-2:0], ge};
        dpl[k] <= src_p[k];
      end
    end
  end

  logic [LW-1:0]        pl1, pl2, pl3, pl4, pl5;
  logic signed [DW-1:0] dsx [3];
  logic signed [MW-1:0] prod1 [3];
  logic signed [MW-1:0] sum2 [3];
  logic signed [C-1:0]  pt2 [3];
  logic signed [C-1:0]  pt3 [3];
  logic signed [C-1:0]  pt4 [3];
  logic signed [C-1:0]  pt5 [3];
  logic signed [C-1:0]  va [3];
  logic signed [C-1:0]  vb [3];
  logic signed [C-1:0]  vc [3];
  logic signed [DW-1:0] ee [3][3];
  logic signed [DW-1:0] ww [3][3];
  logic signed [NPW-1:0] cp3 [3][6];
  logic signed [NW-1:0]  cc4 [3][3];
  logic signed [NW-1:0]  n4 [3];
  logic signed [EPW-1:0] dp5 [3][3];
  logic signed [ESW-1:0] es [3];
  logic                  in_tri;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsx[i]  = DW'(ep[i]) - DW'(sp[i]);
      sum2[i] = MW'(sp[i]) + (prod1[i] >>> T);
      va[i]   = $signed(pl2[1 + 3*NW + i*C +: C]);
      vb[i]   = $signed(pl2[1 + 3*NW + (3+i)*C +: C]);
      vc[i]   = $signed(pl2[1 + 3*NW + (6+i)*C +: C]);
      ee[0][i] = DW'(vb[i]) - DW'(va[i]);
      ee[1][i] = DW'(vc[i]) - DW'(vb[i]);
      ee[2][i] = DW'(va[i]) - DW'(vc[i]);
      ww[0][i] = DW'(pt2[i]) - DW'(va[i]);
      ww[1][i] = DW'(pt2[i]) - DW'(vb[i]);
      ww[2][i] = DW'(pt2[i]) - DW'(va[i]);
      n4[i]    = $signed(pl4[1 + i*NW +: NW]);
      es[i]    = ESW'(dp5[i][0]) + ESW'(dp5[i][1]) + ESW'(dp5[i][2]);
    end
    in_tri = pl5[0] && !es[0][ESW-1] && !es[1][ESW-1] && !es[2][ESW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1 <= dpl[T-1][LW-1:0];
      pl2 <= pl1;
      pl3 <= pl2;
      pl4 <= pl3;
      pl5 <= pl4;
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= dsx[i] * $signed({1'b0, dq[T-1]});
        pt2[i]   <= sum2[i][C-1:0];
        pt3[i]   <= pt2[i];
        pt4[i]   <= pt3[i];
        pt5[i]   <= pt4[i];
      end
      for (int k = 0; k < 3; k++) begin
        cp3[k][0] <= ee[k][1] * ww[k][2];
        cp3[k][1] <= ee[k][2] * ww[k][1];
        cp3[k][2] <= ee[k][2] * ww[k][0];
        cp3[k][3] <= ee[k][0] * ww[k][2];
        cp3[k][4] <= ee[k][0] * ww[k][1];
        cp3[k][5] <= ee[k][1] * ww[k][0];
        for (int j = 0; j < 3; j++) begin
          cc4[k][j] <= NW'(cp3[k][2*j]) - NW'(cp3[k][2*j+1]);
          dp5[k][j] <= n4[j] * cc4[k][j];
        end
      end
      hit   <= in_tri;
      hit_x <= in_tri ? pt5[0] : '0;
      hit_y <= in_tri ? pt5[1] : '0;
      hit_z <= in_tri ? pt5[2] : '0;
    end
  end

endmodule

>>> src/segment_triangle_intersect.sv
`timescale 1ns / 1ps
// Front classifies, queue buffers, back divides for t one quotient bit per stage.
// Throughput: one triangle per cycle whenever neither side stalls.
// Either side stalls on its own; the 4-entry queue absorbs the difference.
// Reset clears the segment registers to zero and empties all stages and the queue.
// ---------------------------------------------------------------------------
// segment_triangle_intersect
// Test a configured line segment against a stream of triangles and return
// the crossing point on a hit.
// ---------------------------------------------------------------------------
module segment_triangle_intersect import sti_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
  localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit_x, hit_y, hit_z
  output logic [OUT_W-1:0]      m_axis_tdata,
  // hit
  output logic                  m_axis_tuser,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [COORD_BITS-1:0] wr_data
);

  localparam int C  = COORD_BITS;
  localparam int QW = sti_qw(C);

  logic [C-1:0]   seg_regs [NUM_REGS];
  logic [6*C-1:0] seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) seg_regs[i] <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_START_X: seg_regs[0] <= wr_data;
        REG_START_Y: seg_regs[1] <= wr_data;
        REG_START_Z: seg_regs[2] <= wr_data;
        REG_END_X:   seg_regs[3] <= wr_data;
        REG_END_Y:   seg_regs[4] <= wr_data;
        REG_END_Z:   seg_regs[5] <= wr_data;
        default: ;
      endcase
    end
  end

  assign seg = {seg_regs[5], seg_regs[4], seg_regs[3],
                seg_regs[2], seg_regs[1], seg_regs[0]};

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_data, b_data;
  logic [C-1:0]  hx, hy, hz;

  sti_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[9*C-1:0]), .seg(seg),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  sti_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  sti_back #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data), .seg(seg),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .hit(m_axis_tuser), .hit_x(hx), .hit_y(hy), .hit_z(hz)
  );

  assign m_axis_tdata = OUT_W'({hz, hy, hx});

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss beat carries a nonzero point");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_data))
    else $error("front dropped a classified beat while the queue was full");

endmodule

>>> test/segment_triangle_intersect_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_triangle_intersect_tb
// Streams triangles against several configured segments, predicts hit flag
// and crossing point in exact integer arithmetic, and checks every result
// beat in order, first with both stream sides idling at random, then at full rate.
// ---------------------------------------------------------------------------
module segment_triangle_intersect_tb import sti_pkg::*;;

  localparam int CB = 16;
  localparam int TF = 16;
  localparam int IN_W = 144;
  localparam int OUT_W = 48;
  localparam int PIPE_CYCLES = 40;

  typedef struct {
    logic signed [CB-1:0] v [9];
  } tri_t;

  typedef struct {
    logic hit;
    logic signed [CB-1:0] px, py, pz;
  } crossing_t;

  typedef struct {
    logic is_cfg;
    reg_idx_t idx;
    logic [CB-1:0] val;
    tri_t shape;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [CB-1:0] wr_data = '0;

  segment_triangle_intersect i_dut (.*);

  job_t pending_jobs[$];
  crossing_t expected_crossings[$];
  longint seg_s[3], seg_e[3];
  int errors = 0;
  int src_idle_pct = 18;
  int snk_idle_pct = 81;
  int quiet_cycles = 0;
  logic stim_done = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // exact 3d cross product; operands stay small enough for 64-bit
  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic edge_inside(longint n[3], longint p[3], longint q[3], longint base[3],
                                       longint pt[3]);
    longint e[3], w[3], c[3];
    logic signed [191:0] acc;
    for (int i = 0; i < 3; i++) begin
      e[i] = q[i] - p[i];
      w[i] = pt[i] - base[i];
    end
    cross3(e, w, c);
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 192'(signed'(n[i])) * 192'(signed'(c[i]));
    return acc >= 0;
  endfunction

  function automatic crossing_t predict_crossing(tri_t t);
    crossing_t r;
    longint a[3], b[3], c[3], ab[3], ac[3], n[3], ds[3], de[3], pt[3];
    logic signed [191:0] d1, d2, num, den, rem;
    longint tq, prod;
    r = '{1'b0, '0, '0, '0};
    for (int i = 0; i < 3; i++) begin
      a[i] = t.v[i];
      b[i] = t.v[3 + i];
      c[i] = t.v[6 + i];
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ds[i] = seg_s[i] - a[i];
      de[i] = seg_e[i] - a[i];
    end
    cross3(ab, ac, n);
    d1 = 0;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      d1 += 192'(signed'(n[i])) * 192'(signed'(ds[i]));
      d2 += 192'(signed'(n[i])) * 192'(signed'(de[i]));
    end
    if (d1 == 0 || d2 == 0 || ((d1 < 0) == (d2 < 0))) return r;
    num = d1 < 0 ? -d1 : d1;
    den = num + (d2 < 0 ? -d2 : d2);
    rem = num;
    tq = 0;
    for (int i = 0; i < TF; i++) begin
      rem = rem <<< 1;
      tq = tq << 1;
      if (rem >= den) begin
        rem -= den;
        tq |= 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      prod = (seg_e[i] - seg_s[i]) * tq;
      pt[i] = seg_s[i] + (prod >>> TF);
    end
    if (!edge_inside(n, a, b, a, pt)) return r;
    if (!edge_inside(n, b, c, b, pt)) return r;
    if (!edge_inside(n, c, a, a, pt)) return r;
    r.hit = 1'b1;
    r.px = CB'(pt[0]);
    r.py = CB'(pt[1]);
    r.pz = CB'(pt[2]);
    return r;
  endfunction

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 64)) - 32);
      default: return CB'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic push_cfg(reg_idx_t idx, logic [CB-1:0] val);
    job_t j;
    j.is_cfg = 1'b1;
    j.idx = idx;
    j.val = val;
    pending_jobs.push_back(j);
  endtask

  task automatic push_tri(logic [CB-1:0] c[9]);
    job_t j;
    j.is_cfg = 1'b0;
    j.idx = REG_START_X;
    j.val = '0;
    for (int i = 0; i < 9; i++) j.shape.v[i] = c[i];
    pending_jobs.push_back(j);
  endtask

  task automatic push_segment(logic [CB-1:0] s[3], logic [CB-1:0] e[3]);
    push_cfg(REG_START_X, s[0]);
    push_cfg(REG_START_Y, s[1]);
    push_cfg(REG_START_Z, s[2]);
    push_cfg(REG_END_X, e[0]);
    push_cfg(REG_END_Y, e[1]);
    push_cfg(REG_END_Z, e[2]);
  endtask

  // triangle, mostly widened in xy to span the segment's range so crossings are common, at times degenerate
  task automatic push_random_tri(int mode);
    logic [CB-1:0] c[9];
    int r;
    r = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
    if (r < 7 && mode != 0) begin
      c[0] = c[0] - 16'd3000;
      c[1] = c[1] - 16'd3000;
      c[3] = c[3] + 16'd3000;
      c[4] = c[4] - 16'd3000;
      c[6] = c[6];
      c[7] = c[7] + 16'd3000;
    end else if (r == 7) begin
      for (int i = 0; i < 3; i++) c[6 + i] = c[i];
    end
    push_tri(c);
  endtask

  initial begin
    logic [CB-1:0] s[3], e[3], c[9];
    for (int i = 0; i < 3; i++) begin
      seg_s[i] = 0;
      seg_e[i] = 0;
    end
    // directed: vertical segment through z=0 plane
    s = '{16'd0, 16'd0, 16'hFF00};
    e = '{16'd0, 16'd0, 16'h0100};
    push_segment(s, e);
    c = '{16'hFF00, 16'hFF00, 16'd0, 16'h0100, 16'hFF00, 16'd0, 16'd0, 16'h0100, 16'd0};
    push_tri(c);
    c = '{16'h0000, 16'h0000, 16'd0, 16'h0100, 16'h0000, 16'd0, 16'd0, 16'h0100, 16'd0};
    push_tri(c); // vertex on the crossing
    c = '{16'h0010, 16'h0010, 16'd0, 16'h0100, 16'h0010, 16'd0, 16'h10, 16'h0100, 16'd0};
    push_tri(c); // outside
    c = '{16'hFF00, 16'hFF00, 16'h0100, 16'h0100, 16'hFF00, 16'h0100, 16'd0, 16'h0100,
          16'h0100};
    push_tri(c); // end touches plane
    c = '{16'hFF00, 16'd0, 16'hFF00, 16'h0100, 16'd0, 16'hFF00, 16'd0, 16'd0, 16'h0100};
    push_tri(c); // parallel plane containing segment
    c = '{16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6, 16'd3, 16'd6, 16'd9};
    push_tri(c); // degenerate
    c = '{16'h8000, 16'h8000, 16'h0010, 16'h7FFF, 16'h8000, 16'h0010, 16'd0, 16'h7FFF,
          16'hFFF0};
    push_tri(c);
    for (int i = 0; i < 9; i++) c[i] = 16'h7FFF;
    push_tri(c);
    for (int i = 0; i < 9; i++) c[i] = 16'h8000;
    push_tri(c);
    // extreme segment
    s = '{16'h8000, 16'h8000, 16'h8000};
    e = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
    push_segment(s, e);
    c = '{16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF,
          16'h8000};
    push_tri(c);
    c = '{16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
          16'h7FFF};
    push_tri(c);
    push_random_tri(0);
    push_random_tri(0);
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 3; i++) begin
        s[i] = rand_coord(ph % 3 == 0 ? 0 : 2);
        e[i] = rand_coord(ph % 3 == 0 ? 0 : 2);
      end
      s[2] = s[2] | 16'h8000;
      e[2] = e[2] & 16'h7FFF;
      push_segment(s, e);
      for (int k = 0; k < 100; k++) push_random_tri(k % 10 == 0 ? 0 : (k % 10 == 1 ? 1 : 2));
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      wr_en <= 1'b0;
    end else if (pending_jobs.size() == 0) begin
      wr_en <= 1'b0;
      s_axis_tvalid <= 1'b0;
      stim_done <= 1'b1;
    end else if (pending_jobs[0].is_cfg) begin
      s_axis_tvalid <= 1'b0;
      if (expected_crossings.size() == 0 && !s_axis_tvalid && quiet_cycles >= PIPE_CYCLES) begin
        job_t j;
        j = pending_jobs.pop_front();
        wr_en <= 1'b1;
        wr_index <= j.idx;
        wr_data <= j.val;
        case (j.idx)
          REG_START_X: seg_s[0] = $signed(j.val);
          REG_START_Y: seg_s[1] = $signed(j.val);
          REG_START_Z: seg_s[2] = $signed(j.val);
          REG_END_X:   seg_e[0] = $signed(j.val);
          REG_END_Y:   seg_e[1] = $signed(j.val);
          REG_END_Z:   seg_e[2] = $signed(j.val);
          default: ;
        endcase
      end else begin
        wr_en <= 1'b0;
      end
    end else if ($urandom_range(0, 99) < src_idle_pct) begin
      wr_en <= 1'b0;
      s_axis_tvalid <= 1'b0;
    end else begin
      job_t j;
      j = pending_jobs.pop_front();
      wr_en <= 1'b0;
      s_axis_tvalid <= 1'b1;
      for (int i = 0; i < 9; i++) s_axis_tdata[i * CB +: CB] <= j.shape.v[i];
      expected_crossings.push_back(predict_crossing(j.shape));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      quiet_cycles <= (m_axis_tvalid || s_axis_tvalid || expected_crossings.size() != 0)
                      ? 0 : quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_crossings.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          crossing_t x;
          x = expected_crossings.pop_front();
          if (m_axis_tuser !== x.hit) begin
            $error("hit: expected %0d got %0d", x.hit, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[15:0] !== x.px) begin
            $error("hit_x: expected %0d got %0d", x.px, $signed(m_axis_tdata[15:0]));
            errors++;
          end
          if (m_axis_tdata[31:16] !== x.py) begin
            $error("hit_y: expected %0d got %0d", x.py, $signed(m_axis_tdata[31:16]));
            errors++;
          end
          if (m_axis_tdata[47:32] !== x.pz) begin
            $error("hit_z: expected %0d got %0d", x.pz, $signed(m_axis_tdata[47:32]));
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_jobs.size() < 560);
    src_idle_pct = 81;
    snk_idle_pct = 18;
    wait (pending_jobs.size() < 280);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    wait (stim_done && expected_crossings.size() == 0);
    repeat (PIPE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
